// File: rtl/fpcg_pkg.sv
// Package for the four point chain geometry block: word types, group type,
// constants and the pair order table. Used by fpcg_front, fpcg_queue, fpcg_back and the top level.
`default_nettype none
package fpcg_pkg;

   localparam int COORD_FRAC_BITS = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [16:0] ONE_PIXEL = 17'(1 << COORD_FRAC_BITS);
   localparam logic [2:0] LAST_PAIR = 3'd5;

   typedef struct packed {
      logic [15:0] file_num;
      logic [23:0] frame_num;
      logic [15:0] x_coord;
      logic [15:0] y_coord;
      logic [15:0] charge;
   } req_type;

   typedef struct packed {
      logic [15:0] file_num_out;
      logic [23:0] frame_num_out;
      logic [15:0] centroid_x;
      logic [15:0] centroid_y;
      logic [16:0] span_length;
      logic [15:0] near_ratio;
      logic [15:0] far_ratio;
      logic [15:0] charge_first;
      logic [15:0] charge_second;
      logic [15:0] charge_third;
      logic [15:0] charge_last;
      logic        degenerate;
   } rsp_type;

   // one complete group of four hits, as queued between front and back
   typedef struct packed {
      logic [15:0]       file_num;
      logic [23:0]       frame_num;
      logic [3:0][15:0]  hit_x;
      logic [3:0][15:0]  hit_y;
      logic [3:0][15:0]  hit_charge;
   } group_type;

   // pair order (0,1),(0,2),(0,3),(1,2),(1,3),(2,3)
   function automatic logic [1:0] pair_first(input logic [2:0] p);
      logic [1:0] r;
      unique case (p)
         3'd0, 3'd1, 3'd2: r = 2'd0;
         3'd3, 3'd4:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] pair_second(input logic [2:0] p);
      logic [1:0] r;
      unique case (p)
         3'd0:       r = 2'd1;
         3'd1, 3'd3: r = 2'd2;
         default:    r = 2'd3;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/fpcg_front.sv
// Front part: gathers four hit words into one group and hands it to the queue.
// Depends on fpcg_pkg.
`default_nettype none
module fpcg_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  accept,
   input  fpcg_pkg::req_type    req_data,
   output logic                 push,
   output fpcg_pkg::group_type  push_group
);

   logic [1:0]          slot_ff;
   fpcg_pkg::group_type grp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
      end else if (accept) begin
         slot_ff <= slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (slot_ff == 2'd0) begin
            grp_ff.file_num  <= req_data.file_num;
            grp_ff.frame_num <= req_data.frame_num;
         end
         grp_ff.hit_x[slot_ff]      <= req_data.x_coord;
         grp_ff.hit_y[slot_ff]      <= req_data.y_coord;
         grp_ff.hit_charge[slot_ff] <= req_data.charge;
      end
   end

   // merge the fourth hit on its way into the queue
   always_comb begin
      push_group               = grp_ff;
      push_group.hit_x[3]      = req_data.x_coord;
      push_group.hit_y[3]      = req_data.y_coord;
      push_group.hit_charge[3] = req_data.charge;
   end

   assign push = accept && (slot_ff == 2'd3);

endmodule
`default_nettype wire

// File: rtl/fpcg_queue.sv
// Two-entry group queue between the front and the back part.
// Depends on fpcg_pkg.
`default_nettype none
module fpcg_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  fpcg_pkg::group_type  push_group,
   input  wire                  pop,
   output fpcg_pkg::group_type  head,
   output logic                 empty,
   output logic                 full
);

   fpcg_pkg::group_type mem_ff [fpcg_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'(fpcg_pkg::QUEUE_DEPTH));

endmodule
`default_nettype wire

// File: rtl/fpcg_isqrt.sv
// Integer square root of a 34-bit value, one result bit per cycle.
// Shared by the span and line length steps of fpcg_back.
`default_nettype none
module fpcg_isqrt (
   input  wire          clock,
   input  wire          reset,
   input  wire          go,
   input  wire  [33:0]  value,
   output logic [16:0]  root,
   output logic         done
);

   logic [33:0] v_ff;
   logic [33:0] r_ff;
   logic [33:0] bit_ff;
   logic        run_ff;
   logic        done_ff;
   logic [34:0] trial;

   assign trial = {1'b0, r_ff} + {1'b0, bit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && bit_ff[0];
         if (go) begin
            run_ff <= 1'b1;
         end else if (run_ff && bit_ff[0]) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         v_ff   <= value;
         r_ff   <= 34'd0;
         bit_ff <= 34'd1 << 32;
      end else if (run_ff) begin
         if ({1'b0, v_ff} >= trial) begin
            v_ff <= v_ff - trial[33:0];
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign root = r_ff[16:0];
   assign done = done_ff;

endmodule
`default_nettype wire

// File: rtl/fpcg_back.sv
// Back part: takes one queued group and works out centroid, span, ordering and ratios
// with one shared multiplier, the square root unit and a bit-serial divider.
// Depends on fpcg_pkg and fpcg_isqrt.
`default_nettype none
module fpcg_back (
   input  wire                  clock,
   input  wire                  reset,
   input  fpcg_pkg::group_type  head,
   input  wire                  empty,
   output logic                 pop,
   output logic                 rsp_valid,
   output fpcg_pkg::rsp_type    rsp_data
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_PSQX   = 5'd1;
   localparam logic [4:0] ST_PSQY   = 5'd2;
   localparam logic [4:0] ST_PCMP   = 5'd3;
   localparam logic [4:0] ST_SPAN   = 5'd4;
   localparam logic [4:0] ST_SPWAIT = 5'd5;
   localparam logic [4:0] ST_LINE   = 5'd6;
   localparam logic [4:0] ST_LSQX   = 5'd7;
   localparam logic [4:0] ST_LSQY   = 5'd8;
   localparam logic [4:0] ST_LEN    = 5'd9;
   localparam logic [4:0] ST_LWAIT  = 5'd10;
   localparam logic [4:0] ST_DEN    = 5'd11;
   localparam logic [4:0] ST_TA     = 5'd12;
   localparam logic [4:0] ST_TB     = 5'd13;
   localparam logic [4:0] ST_ORDER  = 5'd14;
   localparam logic [4:0] ST_DINIT  = 5'd15;
   localparam logic [4:0] ST_DIV    = 5'd16;
   localparam logic [4:0] ST_OUT    = 5'd17;

   logic [4:0]        state_ff, state_in;
   logic [15:0]       file_ff;
   logic [23:0]       frame_ff;
   logic [3:0][15:0]  hx_ff, hy_ff, hq_ff;
   logic [2:0]        pair_ff;
   logic [33:0]       best_ff, sq_ff, d2_ff, den_ff;
   logic [1:0]        e1_ff, e2_ff, m0_ff, m1_ff, ord1_ff, ord2_ff, k_ff;
   logic [16:0]       span_ff, len_ff, x1s_ff;
   logic [15:0]       y1_ff;
   logic signed [17:0] ldx_ff;
   logic signed [16:0] ldy_ff;
   logic signed [35:0] t_ff;
   logic [1:0][35:0]  ac_ff, ap_ff;
   logic [35:0]       near_c_ff, far_c_ff, rem_ff;
   logic [15:0]       quo_ff, near_r_ff, far_r_ff;
   logic [3:0]        cnt_ff;
   logic              div_sel_ff, degen_ff;
   logic              rsp_valid_ff;
   fpcg_pkg::rsp_type rsp_data_ff;

   logic [1:0]         pa, pb, mid, m0_c, m1_c;
   logic signed [16:0] dxp, dyp, yd;
   logic signed [17:0] xd;
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] prod;
   logic signed [36:0] tsum;
   logic [35:0]        tabs, num;
   logic [36:0]        rem2;
   logic               sq_go, sq_done;
   logic [33:0]        sq_val;
   logic [16:0]        sq_root;
   logic [16:0]        x1_ext;
   logic [17:0]        sum_x, sum_y;

   fpcg_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .go    (sq_go),
      .value (sq_val),
      .root  (sq_root),
      .done  (sq_done)
   );

   assign pa  = fpcg_pkg::pair_first(pair_ff);
   assign pb  = fpcg_pkg::pair_second(pair_ff);
   assign dxp = $signed({1'b0, hx_ff[pb]}) - $signed({1'b0, hx_ff[pa]});
   assign dyp = $signed({1'b0, hy_ff[pb]}) - $signed({1'b0, hy_ff[pa]});

   assign mid = k_ff[1] ? m1_ff : m0_ff;
   assign xd  = $signed({2'b00, hx_ff[mid]}) - $signed({1'b0, x1s_ff});
   assign yd  = $signed({1'b0, hy_ff[mid]}) - $signed({1'b0, y1_ff});

   // the two hits that are not end points, in ascending index order
   always_comb begin
      m0_c = 2'd0;
      m1_c = 2'd0;
      priority if (e1_ff != 2'd0 && e2_ff != 2'd0) begin
         m0_c = 2'd0;
         m1_c = (e1_ff != 2'd1 && e2_ff != 2'd1) ? 2'd1 :
                ((e1_ff != 2'd2 && e2_ff != 2'd2) ? 2'd2 : 2'd3);
      end else if (e1_ff != 2'd1 && e2_ff != 2'd1) begin
         m0_c = 2'd1;
         m1_c = (e1_ff != 2'd2 && e2_ff != 2'd2) ? 2'd2 : 2'd3;
      end else begin
         m0_c = 2'd2;
         m1_c = 2'd3;
      end
   end

   always_comb begin
      mul_a = 18'sd0;
      mul_b = 18'sd0;
      unique case (state_ff)
         ST_PSQX: begin
            mul_a = 18'(dxp);
            mul_b = 18'(dxp);
         end
         ST_PSQY: begin
            mul_a = 18'(dyp);
            mul_b = 18'(dyp);
         end
         ST_LSQX: begin
            mul_a = ldx_ff;
            mul_b = ldx_ff;
         end
         ST_LSQY: begin
            mul_a = 18'(ldy_ff);
            mul_b = 18'(ldy_ff);
         end
         ST_DEN: begin
            mul_a = $signed({1'b0, len_ff});
            mul_b = $signed({1'b0, span_ff});
         end
         ST_TA: begin
            mul_a = ldx_ff;
            mul_b = k_ff[0] ? xd : 18'(yd);
         end
         ST_TB: begin
            mul_a = 18'(ldy_ff);
            mul_b = k_ff[0] ? 18'(yd) : xd;
         end
         default: begin
            mul_a = 18'sd0;
            mul_b = 18'sd0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;
   // cross: t - dy*xd, projection: t + dy*yd
   assign tsum = k_ff[0] ? (37'(t_ff) + 37'(prod)) : (37'(t_ff) - 37'(prod));
   assign tabs = tsum[36] ? 36'(-tsum) : tsum[35:0];

   assign num  = div_sel_ff ? far_c_ff : near_c_ff;
   assign rem2 = {rem_ff, 1'b0};

   assign sq_go  = (state_ff == ST_SPAN && best_ff != 34'd0) || (state_ff == ST_LEN);
   assign sq_val = (state_ff == ST_SPAN) ? best_ff : d2_ff;
   assign x1_ext = {1'b0, hx_ff[e1_ff]};
   assign pop    = (state_ff == ST_IDLE) && !empty;

   assign sum_x = 18'(hx_ff[0]) + 18'(hx_ff[1]) + 18'(hx_ff[2]) + 18'(hx_ff[3]);
   assign sum_y = 18'(hy_ff[0]) + 18'(hy_ff[1]) + 18'(hy_ff[2]) + 18'(hy_ff[3]);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (!empty) state_in = ST_PSQX;
         ST_PSQX:   state_in = ST_PSQY;
         ST_PSQY:   state_in = ST_PCMP;
         ST_PCMP:   state_in = (pair_ff == fpcg_pkg::LAST_PAIR) ? ST_SPAN : ST_PSQX;
         ST_SPAN:   state_in = (best_ff == 34'd0) ? ST_OUT : ST_SPWAIT;
         ST_SPWAIT: if (sq_done) state_in = ST_LINE;
         ST_LINE:   state_in = ST_LSQX;
         ST_LSQX:   state_in = ST_LSQY;
         ST_LSQY:   state_in = ST_LEN;
         ST_LEN:    state_in = ST_LWAIT;
         ST_LWAIT:  if (sq_done) state_in = ST_DEN;
         ST_DEN:    state_in = ST_TA;
         ST_TA:     state_in = ST_TB;
         ST_TB:     state_in = (k_ff == 2'd3) ? ST_ORDER : ST_TA;
         ST_ORDER:  state_in = ST_DINIT;
         ST_DINIT: begin
            if (num >= {2'b00, den_ff}) begin
               state_in = div_sel_ff ? ST_OUT : ST_DINIT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == 4'd15) begin
               state_in = div_sel_ff ? ST_OUT : ST_DINIT;
            end
         end
         ST_OUT:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_OUT);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            file_ff  <= head.file_num;
            frame_ff <= head.frame_num;
            hx_ff    <= head.hit_x;
            hy_ff    <= head.hit_y;
            hq_ff    <= head.hit_charge;
            pair_ff  <= 3'd0;
            best_ff  <= 34'd0;
            e1_ff    <= 2'd0;
            e2_ff    <= 2'd0;
            degen_ff <= 1'b0;
         end
         ST_PSQX: sq_ff <= prod[33:0];
         ST_PSQY: d2_ff <= sq_ff + prod[33:0];
         ST_PCMP: begin
            if (d2_ff > best_ff) begin
               best_ff <= d2_ff;
               e1_ff   <= pa;
               e2_ff   <= pb;
            end
            pair_ff <= pair_ff + 3'd1;
         end
         ST_SPAN: degen_ff <= (best_ff == 34'd0);
         ST_SPWAIT: if (sq_done) span_ff <= sq_root;
         ST_LINE: begin
            // move end one by a pixel when the end points share x
            if (hx_ff[e1_ff] == hx_ff[e2_ff]) begin
               x1s_ff <= x1_ext + fpcg_pkg::ONE_PIXEL;
               ldx_ff <= -$signed(18'(fpcg_pkg::ONE_PIXEL));
            end else begin
               x1s_ff <= x1_ext;
               ldx_ff <= $signed({2'b00, hx_ff[e2_ff]}) - $signed({2'b00, hx_ff[e1_ff]});
            end
            y1_ff  <= hy_ff[e1_ff];
            ldy_ff <= $signed({1'b0, hy_ff[e2_ff]}) - $signed({1'b0, hy_ff[e1_ff]});
            m0_ff  <= m0_c;
            m1_ff  <= m1_c;
         end
         ST_LSQX: sq_ff <= prod[33:0];
         ST_LSQY: d2_ff <= sq_ff + prod[33:0];
         ST_LWAIT: if (sq_done) len_ff <= sq_root;
         ST_DEN: begin
            den_ff <= prod[33:0];
            k_ff   <= 2'd0;
         end
         ST_TA: t_ff <= prod;
         ST_TB: begin
            if (k_ff[0]) begin
               ap_ff[k_ff[1]] <= tabs;
            end else begin
               ac_ff[k_ff[1]] <= tabs;
            end
            k_ff <= k_ff + 2'd1;
         end
         ST_ORDER: begin
            // lower-index middle hit wins a tie
            if (ap_ff[0] > ap_ff[1]) begin
               near_c_ff <= ac_ff[1];
               far_c_ff  <= ac_ff[0];
               ord1_ff   <= m1_ff;
               ord2_ff   <= m0_ff;
            end else begin
               near_c_ff <= ac_ff[0];
               far_c_ff  <= ac_ff[1];
               ord1_ff   <= m0_ff;
               ord2_ff   <= m1_ff;
            end
            div_sel_ff <= 1'b0;
         end
         ST_DINIT: begin
            if (num >= {2'b00, den_ff}) begin
               // saturate a ratio of one or more
               if (div_sel_ff) begin
                  far_r_ff <= 16'hFFFF;
               end else begin
                  near_r_ff <= 16'hFFFF;
               end
               div_sel_ff <= 1'b1;
            end else begin
               rem_ff <= num;
               quo_ff <= 16'd0;
               cnt_ff <= 4'd0;
            end
         end
         ST_DIV: begin
            if (rem2 >= {3'b000, den_ff}) begin
               rem_ff <= 36'(rem2 - {3'b000, den_ff});
               quo_ff <= {quo_ff[14:0], 1'b1};
            end else begin
               rem_ff <= rem2[35:0];
               quo_ff <= {quo_ff[14:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               if (div_sel_ff) begin
                  far_r_ff <= {quo_ff[14:0], rem2 >= {3'b000, den_ff}};
               end else begin
                  near_r_ff <= {quo_ff[14:0], rem2 >= {3'b000, den_ff}};
               end
               div_sel_ff <= 1'b1;
            end
         end
         ST_OUT: begin
            rsp_data_ff.file_num_out  <= file_ff;
            rsp_data_ff.frame_num_out <= frame_ff;
            rsp_data_ff.centroid_x    <= sum_x[17:2];
            rsp_data_ff.centroid_y    <= sum_y[17:2];
            rsp_data_ff.degenerate    <= degen_ff;
            if (degen_ff) begin
               rsp_data_ff.span_length   <= 17'd0;
               rsp_data_ff.near_ratio    <= 16'd0;
               rsp_data_ff.far_ratio     <= 16'd0;
               rsp_data_ff.charge_first  <= hq_ff[0];
               rsp_data_ff.charge_second <= hq_ff[1];
               rsp_data_ff.charge_third  <= hq_ff[2];
               rsp_data_ff.charge_last   <= hq_ff[3];
            end else begin
               rsp_data_ff.span_length   <= span_ff;
               rsp_data_ff.near_ratio    <= near_r_ff;
               rsp_data_ff.far_ratio     <= far_r_ff;
               rsp_data_ff.charge_first  <= hq_ff[e1_ff];
               rsp_data_ff.charge_second <= hq_ff[ord1_ff];
               rsp_data_ff.charge_third  <= hq_ff[ord2_ff];
               rsp_data_ff.charge_last   <= hq_ff[e2_ff];
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// File: rtl/four_point_chain_geometry_top.sv
// Top level of the four point chain geometry block: front, group queue, back.
// Depends on fpcg_pkg, fpcg_front, fpcg_queue and fpcg_back.
//
//   channel   ports                     handshake
//   request   start, busy, req_data     word taken when start & !busy
//   response  rsp_valid, rsp_data       strobe, one cycle, never held off
//
// A hit word is taken in the cycle that start is high and busy low; every fourth word closes a group.
// The back part takes one group at a time: the pair scan, a 17-step square root for
// the span and another for the line length, then the two 16-step ratio divisions.
// A saturated ratio skips its division; coincident hits skip everything but the pair scan.
// busy rises only while the two-entry group queue is full.
// Synchronous active-high reset empties the queue and restarts the group count.
`default_nettype none
module four_point_chain_geometry_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  fpcg_pkg::req_type  req_data,
   output logic               rsp_valid,
   output fpcg_pkg::rsp_type  rsp_data
);

   logic                accept;
   logic                push, pop, empty, full;
   fpcg_pkg::group_type push_group, head;

   assign accept = start && !busy;
   assign busy   = full;

   fpcg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .push       (push),
      .push_group (push_group)
   );

   fpcg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   fpcg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
